[hdl/pts_pkg.sv]
// Package for the periodic task scheduler: widths, codes and states.
// No dependencies.
package pts_pkg;
    localparam int MAX_TASKS_DEF = 8;
    localparam int TIME_BITS_DEF = 32;
    localparam int WORK_BITS_DEF = 16;
    localparam int SLOT_BITS     = 3;
    localparam int PERIOD_BITS   = 16;
    localparam int COST_BITS     = 16;
    localparam int OUT_TIME_BITS = 32;

    localparam logic [1:0] MODE_RM  = 2'd0;
    localparam logic [1:0] MODE_EDF = 2'd1;
    localparam logic [1:0] MODE_LLF = 2'd2;

    localparam logic       CMD_WRITE = 1'b0;
    localparam logic       CMD_TICK  = 1'b1;

    localparam logic       REG_MODE  = 1'b0;
    localparam logic       REG_COUNT = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_REL  = 5'b00010,
        ST_SEL  = 5'b00100,
        ST_UPD  = 5'b01000,
        ST_OUT  = 5'b10000
    } t_state;
endpackage

[hdl/periodic_task_scheduler.sv]
// Periodic task scheduler top level: one memory of task records, walked per tick.
// Depends on pts_pkg.
// Flow: a write word updates its record when it is accepted; a tick word walks the record
// memory in order: a release pass over the slots in use, a selection pass, a write-back of
// the chosen record and an output load. With no slots in use a tick goes straight to output.
// Throughput: one word at a time; writes go back to back, a tick blocks input until its
// result is loaded, and a result still waiting in the output register holds the next tick.
// Reset (synchronous, active low) clears time, miss state, mode and slot valid bits and sets count to 1.
module periodic_task_scheduler #(
    parameter int MAX_TASKS = pts_pkg::MAX_TASKS_DEF,
    parameter int TIME_BITS = pts_pkg::TIME_BITS_DEF,
    parameter int WORK_BITS = pts_pkg::WORK_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [3:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: task_slot[2:0], task_period[18:3], task_cost[34:19], zero pad
    input  logic [39:0] s_axis_tdata,
    // tuser: command
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: running_slot[2:0], cpu_idle[3], deadline_miss[4],
    // missed_slot[7:5], tick_time[39:8]
    output logic [39:0] m_axis_tdata
);
    localparam int IDX_BITS = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_BITS = $clog2(MAX_TASKS + 1);
    localparam int KEY_BITS = (TIME_BITS > pts_pkg::PERIOD_BITS) ? TIME_BITS
                                                                 : pts_pkg::PERIOD_BITS;
    localparam int LAX_BITS = TIME_BITS + 1;
    localparam int REC_BITS = pts_pkg::PERIOD_BITS + WORK_BITS + WORK_BITS
                              + TIME_BITS + TIME_BITS;

    typedef struct packed {
        logic [pts_pkg::PERIOD_BITS-1:0] period;
        logic [WORK_BITS-1:0]            cost;
        logic [WORK_BITS-1:0]            work;
        logic [TIME_BITS-1:0]            release_t;
        logic [TIME_BITS-1:0]            deadline;
    } t_rec;

    // record memory: one entry per slot, one write port and one registered read port
    logic [REC_BITS-1:0] mem [MAX_TASKS];
    logic                mem_we;
    logic [IDX_BITS-1:0] mem_waddr;
    t_rec                mem_wdata;
    logic [IDX_BITS-1:0] mem_raddr;
    t_rec                r_rd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd <= mem[mem_raddr];
    end

    pts_pkg::t_state      r_state;
    logic [1:0]           r_mode;
    logic [3:0]           r_count;
    logic [TIME_BITS-1:0] r_now;
    logic                 r_halt;
    logic [pts_pkg::SLOT_BITS-1:0] r_miss;
    logic [MAX_TASKS-1:0] r_written;
    logic [IDX_BITS-1:0]  r_idx;     // slot whose read is in flight
    logic                 r_rdv;     // r_rd holds slot r_idx-1 data
    logic                 r_found;
    logic [IDX_BITS-1:0]  r_best;
    logic [KEY_BITS-1:0]  r_bkey;
    logic signed [LAX_BITS:0] r_blax;
    t_rec                 r_brec;
    logic                 r_ovld;
    logic [39:0]          r_odata;

    logic [CNT_BITS-1:0] n_used;
    always_comb begin
        if (int'(r_count) > MAX_TASKS) n_used = CNT_BITS'(MAX_TASKS);
        else                           n_used = CNT_BITS'(r_count);
    end

    logic s_acc;
    logic out_free;   // output register can take a new word this cycle
    assign s_axis_tready = (r_state == pts_pkg::ST_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_ovld || m_axis_tready;
    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = r_odata;

    logic [pts_pkg::SLOT_BITS-1:0] in_slot;
    logic [15:0] in_period, in_cost;
    assign in_slot   = s_axis_tdata[2:0];
    assign in_period = s_axis_tdata[18:3];
    assign in_cost   = s_axis_tdata[34:19];

    // slot being examined is r_idx-1; its data is in r_rd
    logic [IDX_BITS-1:0] cur;
    assign cur = r_idx - IDX_BITS'(1);
    t_rec rd;
    always_comb begin
        rd = r_rd;
        if (!r_written[cur]) begin
            rd.period = '0;
            rd.cost   = '0;
            rd.work   = '0;
            rd.release_t = '0;
            rd.deadline  = '0;
        end
    end

    logic [TIME_BITS-1:0] dl_dist;
    logic [KEY_BITS-1:0]  key;
    logic signed [LAX_BITS:0] lax;
    logic take;
    assign dl_dist = rd.deadline - r_now;
    assign lax  = $signed({2'b00, dl_dist}) - $signed((LAX_BITS+1)'(rd.work));
    always_comb begin
        if (r_mode == pts_pkg::MODE_EDF || r_mode == pts_pkg::MODE_LLF)
            key = KEY_BITS'(dl_dist);
        else
            key = KEY_BITS'(rd.period);
        if (!r_found)                        take = 1'b1;
        else if (r_mode == pts_pkg::MODE_LLF) take = lax <= r_blax;
        else                                 take = key <= r_bkey;
    end

    logic last_rd;   // r_idx has walked past the last slot in use
    assign last_rd = ({1'b0, r_idx} == (IDX_BITS+1)'(n_used)) ||
                     (r_idx == '0 && n_used == CNT_BITS'(MAX_TASKS));

    logic [TIME_BITS-1:0] rel_t;
    assign rel_t = r_now + TIME_BITS'(rd.period);

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = cur;
        mem_wdata = rd;
        mem_raddr = r_idx;
        if (s_acc && s_axis_tuser == pts_pkg::CMD_WRITE) begin
            mem_waddr = IDX_BITS'(in_slot);
            mem_we    = ({1'b0, in_slot} < 4'(MAX_TASKS)) || (MAX_TASKS >= 8);
            mem_wdata.period    = in_period;
            mem_wdata.cost      = WORK_BITS'(in_cost);
            mem_wdata.work      = '0;
            mem_wdata.release_t = r_now;
            mem_wdata.deadline  = r_now;
        end else if (r_state == pts_pkg::ST_REL && r_rdv && !r_halt &&
                     rd.period != '0 && rd.release_t == r_now &&
                     rd.work == '0) begin
            mem_we = 1'b1;
            mem_wdata.work      = rd.cost;
            mem_wdata.release_t = rel_t;
            mem_wdata.deadline  = rel_t;
        end else if (r_state == pts_pkg::ST_UPD && r_found) begin
            mem_we    = 1'b1;
            mem_waddr = r_best;
            mem_wdata = r_brec;
            mem_wdata.work = r_brec.work - WORK_BITS'(1);
        end
    end

    function automatic logic [pts_pkg::OUT_TIME_BITS-1:0] OUT_T(
        input logic [TIME_BITS-1:0] t);
        logic [KEY_BITS+pts_pkg::OUT_TIME_BITS-1:0] w;
        w = '0;
        w[TIME_BITS-1:0] = t;
        return w[pts_pkg::OUT_TIME_BITS-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= pts_pkg::ST_IDLE;
            r_mode    <= pts_pkg::MODE_RM;
            r_count   <= 4'd1;
            r_now     <= '0;
            r_halt    <= 1'b0;
            r_miss    <= '0;
            r_written <= '0;
            r_idx     <= '0;
            r_rdv     <= 1'b0;
            r_found   <= 1'b0;
            r_ovld    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == pts_pkg::REG_MODE) r_mode <= i_cfg_data[1:0];
                else                                  r_count <= i_cfg_data;
            end
            if (r_state == pts_pkg::ST_OUT && out_free) r_ovld <= 1'b1;
            else if (m_axis_tready)                      r_ovld <= 1'b0;
            unique case (r_state)
                pts_pkg::ST_IDLE: begin
                    if (s_acc) begin
                        if (s_axis_tuser == pts_pkg::CMD_WRITE) begin
                            if (mem_we) r_written[mem_waddr] <= 1'b1;
                        end else begin
                            // start a release walk: read slot 0 first
                            r_idx   <= IDX_BITS'(1);
                            r_rdv   <= n_used != '0;
                            r_found <= 1'b0;
                            r_state <= (n_used != '0) ? pts_pkg::ST_REL
                                                      : pts_pkg::ST_OUT;
                        end
                    end
                end
                pts_pkg::ST_REL: begin
                    if (!r_halt && rd.period != '0 && rd.release_t == r_now &&
                        rd.work != '0) begin
                        r_halt <= 1'b1;
                        r_miss <= pts_pkg::SLOT_BITS'(cur);
                    end
                    if (last_rd) begin
                        r_idx   <= '0;
                        r_state <= pts_pkg::ST_SEL;
                    end else begin
                        r_idx <= r_idx + IDX_BITS'(1);
                    end
                end
                pts_pkg::ST_SEL: begin
                    // first cycle reads slot 0 again after the write-back
                    if (r_rdv) begin
                        if (!r_halt && rd.work != '0 && take) begin
                            r_found <= 1'b1;
                            r_best  <= cur;
                            r_bkey  <= key;
                            r_blax  <= lax;
                            r_brec  <= rd;
                        end
                    end
                    if (last_rd && r_rdv) begin
                        r_state <= pts_pkg::ST_UPD;
                    end else begin
                        r_idx <= r_idx + IDX_BITS'(1);
                    end
                    r_rdv <= 1'b1;
                end
                pts_pkg::ST_UPD: begin
                    r_state <= pts_pkg::ST_OUT;
                end
                pts_pkg::ST_OUT: begin
                    // hold the finished tick while the previous word still waits
                    if (out_free) begin
                        r_odata <= {OUT_T(r_now), r_miss, r_halt,
                                    !(r_found && !r_halt),
                                    (r_found && !r_halt) ?
                                        pts_pkg::SLOT_BITS'(r_best) : 3'd0};
                        if (!r_halt) r_now <= r_now + TIME_BITS'(1);
                        r_idx   <= '0;
                        r_state <= pts_pkg::ST_IDLE;
                    end
                end
                default: r_state <= pts_pkg::ST_IDLE;
            endcase
            if (r_state == pts_pkg::ST_REL && last_rd) r_rdv <= 1'b0;
        end
    end
endmodule

[sim/periodic_task_scheduler_tb.sv]
// Testbench for periodic_task_scheduler: drives write and tick words on the input
// stream, predicts each tick result with its own scheduler model and checks the output.
// Depends on pts_pkg and the periodic_task_scheduler RTL.
`timescale 1ns / 100ps

module periodic_task_scheduler_tb;

    typedef struct packed {
        logic [2:0]  slot;
        logic        idle;
        logic        miss;
        logic [2:0]  miss_slot;
        logic [31:0] tick;
    } t_sched_out;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [3:0]  i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;

    periodic_task_scheduler u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Shadow scheduler state
    logic [1:0]  mdl_mode;
    logic [3:0]  mdl_count;
    logic [15:0] mdl_period [8];
    logic [15:0] mdl_cost   [8];
    logic [15:0] mdl_work   [8];
    logic [31:0] mdl_release[8];
    logic [31:0] mdl_dline  [8];
    logic [31:0] mdl_now;
    logic        mdl_halted;
    logic [2:0]  mdl_miss_slot;

    t_sched_out  pending_ticks[$];
    int          fail_count;
    int          quiet_cycles;
    bit          free_run;       // no idling on either side
    int          sink_hold;      // cycles left in an output stall

    localparam int WATCHDOG_LIMIT = 20000;

    always begin
        i_clk = 1'b0; #4;
        i_clk = 1'b1; #4;
    end

    task automatic report_mismatch(input string what, input logic [39:0] got,
                                   input logic [39:0] want);
        $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // Least laxity compare: d1 - w1 <= d2 - w2 over 33-bit sums
    function automatic bit laxity_le(input logic [31:0] d1, input logic [15:0] w1,
                                     input logic [31:0] d2, input logic [15:0] w2);
        logic [32:0] a;
        logic [32:0] b;
        a = {1'b0, d1} + {17'd0, w2};
        b = {1'b0, d2} + {17'd0, w1};
        return a <= b;
    endfunction

    // Apply one accepted word to the shadow state; queue the tick outcome
    task automatic predict_word(input logic cmd, input logic [2:0] slot,
                                input logic [15:0] period, input logic [15:0] cost);
        int n;
        int best;
        bit found;
        bit take;
        logic [31:0] key;
        logic [31:0] bkey;
        logic [15:0] bwork;
        logic [31:0] t;
        t_sched_out r;
        found = 0; best = 0; bkey = '0; bwork = '0;
        if (cmd == pts_pkg::CMD_WRITE) begin
            mdl_period[slot]  = period;
            mdl_cost[slot]    = cost;
            mdl_work[slot]    = '0;
            mdl_release[slot] = mdl_now;
            mdl_dline[slot]   = mdl_now;
            return;
        end
        n = (mdl_count > 8) ? 8 : mdl_count;
        t = mdl_now;
        if (!mdl_halted) begin
            for (int i = 0; i < n; i++) begin
                if (mdl_period[i] == 0 || mdl_release[i] != t) continue;
                if (mdl_work[i] != 0) begin
                    if (!mdl_halted) mdl_miss_slot = i[2:0];
                    mdl_halted = 1'b1;
                end else begin
                    mdl_work[i]    = mdl_cost[i];
                    mdl_release[i] = t + mdl_period[i];
                    mdl_dline[i]   = mdl_release[i];
                end
            end
        end
        if (!mdl_halted) begin
            for (int i = 0; i < n; i++) begin
                if (mdl_work[i] == 0) continue;
                if (mdl_mode == pts_pkg::MODE_EDF || mdl_mode == pts_pkg::MODE_LLF)
                    key = mdl_dline[i] - t;
                else
                    key = {16'd0, mdl_period[i]};
                if (!found) take = 1;
                else if (mdl_mode == pts_pkg::MODE_LLF)
                    take = laxity_le(key, mdl_work[i], bkey, bwork);
                else take = key <= bkey;
                if (take) begin
                    found = 1; best = i; bkey = key; bwork = mdl_work[i];
                end
            end
            if (found) mdl_work[best] = mdl_work[best] - 1'b1;
            mdl_now = t + 1;
        end
        r.slot      = found ? best[2:0] : 3'd0;
        r.idle      = !found;
        r.miss      = mdl_halted;
        r.miss_slot = mdl_miss_slot;
        r.tick      = t;
        pending_ticks.push_back(r);
    endtask

    // Send one word; idle bursts ahead of it unless running free
    task automatic send_word(input logic cmd, input logic [2:0] slot,
                             input logic [15:0] period, input logic [15:0] cost);
        if (!free_run && $urandom_range(3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {5'd0, cost, period, slot};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_word(cmd, slot, period, cost);
    endtask

    task automatic tick_n(input int n);
        repeat (n) send_word(pts_pkg::CMD_TICK, 3'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic load_task(input int slot, input int period, input int cost);
        send_word(pts_pkg::CMD_WRITE, slot[2:0], period[15:0], cost[15:0]);
    endtask

    // Drop valid, wait until every tick result has come out, then let the block settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_ticks.size() != 0) @(posedge i_clk);
        repeat (24) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [3:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == pts_pkg::REG_MODE) mdl_mode = value[1:0];
        else mdl_count = value;
        @(posedge i_clk);
    endtask

    // Directed: extremes of fields, each policy, preemption, ties
    task automatic test_directed();
        write_reg(pts_pkg::REG_COUNT, 4'd8);
        write_reg(pts_pkg::REG_MODE, 4'(pts_pkg::MODE_RM));
        load_task(0, 65535, 1);
        load_task(1, 64, 1);
        load_task(2, 64, 1);
        load_task(5, 64, 1);
        load_task(6, 64, 1);
        load_task(7, 4, 1);
        load_task(3, 8, 2);
        load_task(4, 8, 2);          // tie with slot 3: higher index wins
        tick_n(8);
        drain();
        write_reg(pts_pkg::REG_MODE, 4'(pts_pkg::MODE_EDF));
        load_task(7, 65535, 100);
        load_task(0, 5, 2);
        tick_n(6);
        drain();
        write_reg(pts_pkg::REG_MODE, 4'(pts_pkg::MODE_LLF));
        load_task(1, 9, 4);
        load_task(2, 12, 9);
        tick_n(6);
        drain();
    endtask

    // Overload a slot so that a miss halts the block, then tick on
    task automatic test_deadline_miss();
        write_reg(pts_pkg::REG_COUNT, 4'd2);
        write_reg(pts_pkg::REG_MODE, 4'(pts_pkg::MODE_RM));
        load_task(0, 2, 2);
        load_task(1, 3, 2);
        tick_n(10);
        load_task(1, 4, 1);          // writes still take effect while halted
        tick_n(3);
        drain();
    endtask

    // Random mixes; the block halts for good once a miss occurs, so
    // most task sets keep utilization low and only a few overload.
    task automatic test_random();
        int items;
        int cnt;
        items = 0;
        while (items < 470) begin
            if (!free_run && $urandom_range(9) == 0) begin
                // hold off until all results are in
                drain();
            end
            items++;
            if (!free_run && $urandom_range(7) == 0) begin
                cnt = $urandom_range(1, 15);
                if (pending_ticks.size() == 0) begin
                    drain();
                    write_reg(pts_pkg::REG_COUNT, cnt[3:0]);
                    write_reg(pts_pkg::REG_MODE, 4'($urandom_range(3)));
                end
            end else if ($urandom_range(4) == 0) begin
                if ($urandom_range(9) == 0)
                    load_task($urandom_range(7), $urandom_range(1, 65535),
                              $urandom_range(1, 65535));
                else
                    load_task($urandom_range(7), $urandom_range(8, 40),
                              $urandom_range(1, 3));
            end else begin
                tick_n(1);
            end
            if (items > 400) free_run = 1;
        end
    endtask

    // Result checker
    always @(posedge i_clk) begin
        t_sched_out got;
        t_sched_out want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            quiet_cycles <= 0;
            got = {m_axis_tdata[2:0], m_axis_tdata[3], m_axis_tdata[4],
                   m_axis_tdata[7:5], m_axis_tdata[39:8]};
            if (pending_ticks.size() == 0) begin
                report_mismatch("unexpected word", m_axis_tdata, '0);
            end else begin
                want = pending_ticks.pop_front();
                if (got.slot != want.slot)
                    report_mismatch("running_slot", 40'(got.slot), 40'(want.slot));
                if (got.idle != want.idle)
                    report_mismatch("cpu_idle", 40'(got.idle), 40'(want.idle));
                if (got.miss != want.miss)
                    report_mismatch("deadline_miss", 40'(got.miss), 40'(want.miss));
                if (got.miss_slot != want.miss_slot)
                    report_mismatch("missed_slot", 40'(got.miss_slot),
                                    40'(want.miss_slot));
                if (got.tick != want.tick)
                    report_mismatch("tick_time", 40'(got.tick), 40'(want.tick));
            end
        end else if (s_axis_tvalid && s_axis_tready) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Output back pressure in random bursts
    always @(posedge i_clk) begin
        if (free_run) begin
            m_axis_tready <= 1'b1;
        end else if (sink_hold > 0) begin
            sink_hold     <= sink_hold - 1;
            m_axis_tready <= (sink_hold == 1);
        end else if ($urandom_range(4) == 0) begin
            sink_hold     <= $urandom_range(1, 6);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Watchdog on cycles with no accepted word
    always @(posedge i_clk) begin
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("periodic_task_scheduler test failed");
            $finish;
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= 1'b0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        m_axis_tready <= 1'b1;
        fail_count    = 0;
        quiet_cycles  = 0;
        free_run      = 0;
        mdl_mode      = pts_pkg::MODE_RM;
        mdl_count     = 4'd1;
        mdl_now       = '0;
        mdl_halted    = 1'b0;
        mdl_miss_slot = '0;
        for (int i = 0; i < 8; i++) begin
            mdl_period[i] = '0; mdl_cost[i] = '0; mdl_work[i] = '0;
            mdl_release[i] = '0; mdl_dline[i] = '0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_deadline_miss();
        // Reset is never repeated, so the block stays halted from here;
        // the random part still checks writes and halted ticks.
        test_random();
        drain();
        if (fail_count == 0)
            $display("periodic_task_scheduler test passed");
        else
            $display("periodic_task_scheduler test failed");
        $finish;
    end
endmodule
